>>> rtl/core/cdbm_pkg.sv
`default_nettype none

package cdbm_pkg;

	// field widths
	localparam int ELAPSED_W = 40;
	localparam int COUNT_W   = 64;
	localparam int BW_W      = 48;
	localparam int HALF_W    = 32;

	// fixed-point and scaling constants
	localparam int FRACTION_BITS_DEF = 16;
	localparam int US_W              = 20;
	localparam logic [US_W-1:0] US_PER_S = US_W'(1000000);
	localparam int MIB_SHIFT         = 20;
	localparam int MUL_W             = HALF_W + US_W;
	localparam int PROD_W            = COUNT_W + US_W;
	localparam logic [BW_W-1:0] BW_MAX = '1;

	// result status codes
	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_UNAVL = 1'b1;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic eval;
		logic mul_lo;
		logic mul_hi;
		logic div_step;
		logic emit;
	} cdbm_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic normal;
		logic out_free;
	} cdbm_sts_t;

endpackage

`default_nettype wire

>>> rtl/core/cdbm_in_if.sv
`default_nettype none

interface cdbm_in_if
	import cdbm_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic [ELAPSED_W-1:0] elapsed_us;
	logic [COUNT_W-1:0]   byte_count;
	logic                 count_valid;

	modport source (output valid, output elapsed_us, output byte_count, output count_valid,
		input ready);
	modport sink (input valid, input elapsed_us, input byte_count, input count_valid,
		output ready);
endinterface

`default_nettype wire

>>> rtl/core/cdbm_out_if.sv
`default_nettype none

interface cdbm_out_if
	import cdbm_pkg::*;
();
	logic            valid;
	logic            ready;
	logic            status;
	logic [BW_W-1:0] bandwidth;

	modport source (output valid, output status, output bandwidth, input ready);
	modport sink (input valid, input status, input bandwidth, output ready);
endinterface

`default_nettype wire

>>> rtl/core/cdbm_ctrl.sv
`default_nettype none

module cdbm_ctrl
	import cdbm_pkg::*;
#(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire cdbm_sts_t sts,
	output cdbm_cmd_t      cmd
);

	localparam int ITER  = COUNT_W + FRACTION_BITS;
	localparam int CNT_W = $clog2(ITER);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(ITER - 1);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_EVAL   = 6'b000010,
		ST_MUL_LO = 6'b000100,
		ST_MUL_HI = 6'b001000,
		ST_DIV    = 6'b010000,
		ST_EMIT   = 6'b100000
	} state_t;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q;

	// next state and commands
	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		in_ready     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
				if (in_valid) state_d = ST_EVAL;
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = sts.normal ? ST_MUL_LO : ST_EMIT;
			end
			ST_MUL_LO: begin
				cmd.mul_lo = 1'b1;
				state_d    = ST_MUL_HI;
			end
			ST_MUL_HI: begin
				cmd.mul_hi = 1'b1;
				state_d    = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == '0) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				cmd.emit = sts.out_free;
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state register and divide step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_MUL_HI) cnt_q <= LAST;
			else if (state_q == ST_DIV) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/cdbm_dp.sv
`default_nettype none

module cdbm_dp
	import cdbm_pkg::*;
#(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire cdbm_cmd_t            cmd,
	output cdbm_sts_t                 sts,
	input  wire logic [ELAPSED_W-1:0] elapsed_us,
	input  wire logic [COUNT_W-1:0]   byte_count,
	input  wire logic                 count_valid,
	output logic                      res_valid,
	input  wire logic                 res_ready,
	output logic                      res_status,
	output logic [BW_W-1:0]           res_bandwidth
);

	localparam int EXT_W = PROD_W + FRACTION_BITS;
	localparam int DVD_W = EXT_W - MIB_SHIFT;

	// captured sample
	logic [ELAPSED_W-1:0] elapsed_q;
	logic [COUNT_W-1:0]   count_q;
	logic                 cvalid_q;

	// meter state
	logic [COUNT_W-1:0]   prev_q;
	logic                 based_q;

	// working registers
	logic [COUNT_W-1:0]   delta_q;
	logic [PROD_W-1:0]    prod_q;
	logic [DVD_W-1:0]     dvd_q;
	logic [ELAPSED_W-1:0] rem_q;
	logic [BW_W-1:0]      quo_q;
	logic                 sat_q;
	logic                 norm_q;
	logic                 stat_q;

	// output register
	logic                 out_valid_q;
	logic                 out_status_q;
	logic [BW_W-1:0]      out_bw_q;

	logic                 go_normal;
	logic [HALF_W-1:0]    mul_in;
	logic [MUL_W-1:0]     mul_out;
	logic [PROD_W-1:0]    prod_sum;
	logic [EXT_W-1:0]     ext;
	logic [ELAPSED_W:0]   rem_sh;
	logic                 rem_ge;
	logic [ELAPSED_W-1:0] rem_nx;
	logic [BW_W-1:0]      bw_res;

	// classification of the captured sample
	assign go_normal = cvalid_q && based_q && (elapsed_q != '0) && (count_q >= prev_q);

	// shared 32x20 multiplier, low half then high half
	assign mul_in   = cmd.mul_hi ? delta_q[COUNT_W-1:HALF_W] : delta_q[HALF_W-1:0];
	assign mul_out  = MUL_W'(mul_in) * MUL_W'(US_PER_S);
	assign prod_sum = prod_q + (PROD_W'(mul_out) << HALF_W);
	assign ext      = EXT_W'(prod_sum) << FRACTION_BITS;

	// restoring divide step by elapsed time
	assign rem_sh = {rem_q, dvd_q[DVD_W-1]};
	assign rem_ge = rem_sh >= {1'b0, elapsed_q};
	assign rem_nx = rem_ge ? ELAPSED_W'(rem_sh - {1'b0, elapsed_q}) : rem_sh[ELAPSED_W-1:0];

	// final value, zero when unavailable
	assign bw_res = !norm_q ? '0 : (sat_q ? BW_MAX : quo_q);

	assign sts.normal   = go_normal;
	assign sts.out_free = !out_valid_q || res_ready;

	// per-case update of the baseline flag and the stored count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			based_q <= 1'b0;
		end else if (cmd.eval) begin
			if (!cvalid_q) begin
				based_q <= 1'b0;
			end else begin
				prev_q  <= count_q;
				if (!based_q || elapsed_q == '0) based_q <= 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			elapsed_q <= elapsed_us;
			count_q   <= byte_count;
			cvalid_q  <= count_valid;
		end
		if (cmd.eval) begin
			delta_q <= count_q - prev_q;
			norm_q  <= go_normal;
			stat_q  <= (go_normal || (cvalid_q && elapsed_q == '0)) ? STATUS_OK : STATUS_UNAVL;
		end
		if (cmd.mul_lo) prod_q <= PROD_W'(mul_out);
		if (cmd.mul_hi) begin
			dvd_q <= ext[EXT_W-1:MIB_SHIFT];
			rem_q <= '0;
			quo_q <= '0;
			sat_q <= 1'b0;
		end else if (cmd.div_step) begin
			dvd_q <= dvd_q << 1;
			rem_q <= rem_nx;
			quo_q <= {quo_q[BW_W-2:0], rem_ge};
			sat_q <= sat_q | quo_q[BW_W-1];
		end
		if (cmd.emit) begin
			out_status_q <= stat_q;
			out_bw_q     <= bw_res;
		end
	end

	// result beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign res_valid     = out_valid_q;
	assign res_status    = out_status_q;
	assign res_bandwidth = out_bw_q;

endmodule

`default_nettype wire

>>> rtl/core/counter_delta_bandwidth_meter.sv
// sequence: capture, evaluate and emit when no rate is computed; capture,
//   evaluate, multiply low and high halves, divide and emit when one is
// throughput: one sample in work at a time; the bit-serial divider takes
//   one quotient bit per cycle over 64 + FRACTION_BITS bits
// reset: arst_n clears the baseline, the stored count and all handshake state
`default_nettype none

module counter_delta_bandwidth_meter
	import cdbm_pkg::*;
#(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	cdbm_in_if.sink    sample,
	cdbm_out_if.source result
);

	cdbm_cmd_t cmd;
	cdbm_sts_t sts;

	// controller
	cdbm_ctrl #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.in_ready (sample.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath
	cdbm_dp #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.elapsed_us    (sample.elapsed_us),
		.byte_count    (sample.byte_count),
		.count_valid   (sample.count_valid),
		.res_valid     (result.valid),
		.res_ready     (result.ready),
		.res_status    (result.status),
		.res_bandwidth (result.bandwidth)
	);

	// an unavailable result carries zero bandwidth
	a_unavl_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.status == STATUS_UNAVL |-> result.bandwidth == '0)
		else $error("unavailable result with nonzero bandwidth");

	// one sample in flight: busy right after a sample beat
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		sample.valid && sample.ready |=> !sample.ready)
		else $error("sample taken while previous still in work");

	// a new result only comes out of work in progress
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(!sample.ready))
		else $error("result appeared without a sample in work");

endmodule

`default_nettype wire

>>> sim/tb_counter_delta_bandwidth_meter.sv
`timescale 1ns / 1ps

module tb_counter_delta_bandwidth_meter;
	import cdbm_pkg::*;

	localparam int FRAC      = FRACTION_BITS_DEF;
	localparam int N_RANDOM  = 1250;
	localparam int DRAIN_CYC = 2 * (68 + FRAC);
	localparam int HOLD_AT   = 900;
	localparam int HOLD_CYC  = 600;
	localparam logic [ELAPSED_W-1:0] EL_MAX  = '1;
	localparam logic [COUNT_W-1:0]   CNT_MAX = '1;

	typedef struct packed {
		logic            status;
		logic [BW_W-1:0] bandwidth;
	} rate_result_t;

	// tracks the meter's baseline and queues the rate each sample should yield
	class rate_scoreboard;
		rate_result_t       pending_rates[$];
		logic [COUNT_W-1:0] last_count;
		bit                 has_baseline;
		int                 errors;

		function new();
			last_count   = '0;
			has_baseline = 1'b0;
			errors       = 0;
		endfunction

		// exact floor(delta * 1e6 * 2^FRAC / (elapsed * 2^20)), saturated
		function logic [BW_W-1:0] mib_rate(logic [COUNT_W-1:0] delta,
				logic [ELAPSED_W-1:0] el);
			logic [127:0] num;
			logic [127:0] den;
			logic [127:0] quo;
			num = (128'(delta) * 128'(US_PER_S)) << FRAC;
			den = 128'(el) << MIB_SHIFT;
			quo = num / den;
			if (quo > 128'(BW_MAX))
				return BW_MAX;
			return quo[BW_W-1:0];
		endfunction

		function void note_sample(logic [ELAPSED_W-1:0] el, logic [COUNT_W-1:0] cnt,
				logic cv);
			rate_result_t r;
			r.status    = STATUS_UNAVL;
			r.bandwidth = '0;
			if (!cv) begin
				has_baseline = 1'b0;
			end else if (!has_baseline || el == '0) begin
				// fresh baseline; zero elapsed reports a valid zero rate
				last_count   = cnt;
				has_baseline = 1'b1;
				if (el == '0)
					r.status = STATUS_OK;
			end else if (cnt < last_count) begin
				// counter went backwards
				last_count = cnt;
			end else begin
				r.status    = STATUS_OK;
				r.bandwidth = mib_rate(cnt - last_count, el);
				last_count  = cnt;
			end
			pending_rates.push_back(r);
		endfunction

		task report(string msg);
			errors++;
			$display("%0t mismatch: %s", $time, msg);
		endtask

		task check_result(logic status, logic [BW_W-1:0] bw);
			rate_result_t want;
			if (pending_rates.size() == 0) begin
				report($sformatf("unexpected beat status=%0b bandwidth=%h", status, bw));
				return;
			end
			want = pending_rates.pop_front();
			if (status !== want.status)
				report($sformatf("status %0b, wanted %0b", status, want.status));
			if (bw !== want.bandwidth)
				report($sformatf("bandwidth %h, wanted %h", bw, want.bandwidth));
		endtask
	endclass

	logic           clk;
	logic           arst_n;
	int             src_idle_pct;
	int             snk_idle_pct;
	rate_scoreboard sb;

	cdbm_in_if  sample ();
	cdbm_out_if result ();

	counter_delta_bandwidth_meter #(
		.FRACTION_BITS(FRAC)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.sample(sample),
		.result(result)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run limit
	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic logic [COUNT_W-1:0] rand_count();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [ELAPSED_W-1:0] rand_elapsed();
		return ELAPSED_W'({$urandom, $urandom});
	endfunction

	// offer one sample beat, with random idle cycles ahead of it
	task automatic send_sample(logic [ELAPSED_W-1:0] el, logic [COUNT_W-1:0] cnt,
			logic cv);
		while ($urandom_range(99) < src_idle_pct) begin
			sample.valid <= 1'b0;
			@(posedge clk);
		end
		sample.valid       <= 1'b1;
		sample.elapsed_us  <= el;
		sample.byte_count  <= cnt;
		sample.count_valid <= cv;
		@(posedge clk);
		while (!sample.ready)
			@(posedge clk);
		sb.note_sample(el, cnt, cv);
	endtask

	// result side: check beats, random stalls, one long hold-off
	initial begin
		int beats;
		int hold_left;
		beats     = 0;
		hold_left = 0;
		result.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (result.valid && result.ready) begin
				sb.check_result(result.status, result.bandwidth);
				beats++;
				if (beats == HOLD_AT)
					hold_left = HOLD_CYC;
			end
			if (hold_left > 0) begin
				result.ready <= 1'b0;
				hold_left--;
			end else begin
				result.ready <= ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	// reset and sample stimulus
	initial begin
		logic [COUNT_W-1:0]   run_count;
		logic [COUNT_W-1:0]   cnt;
		logic [ELAPSED_W-1:0] el;
		logic                 cv;
		int                   pick;
		sb           = new();
		src_idle_pct = 22;
		snk_idle_pct = 73;
		run_count    = '0;
		arst_n       = 1'b0;
		sample.valid       <= 1'b0;
		sample.elapsed_us  <= '0;
		sample.byte_count  <= '0;
		sample.count_valid <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// invalid reading before any baseline
		send_sample('0, '0, 1'b0);
		// first valid reading only sets the baseline
		send_sample(40'd1000, 64'd0, 1'b1);
		send_sample(40'd1000, 64'd1048576, 1'b1);
		// largest delta over one microsecond saturates
		send_sample(40'd1, CNT_MAX, 1'b1);
		// counter went backwards
		send_sample(40'd5, 64'd0, 1'b1);
		// no change over the longest interval
		send_sample(EL_MAX, 64'd0, 1'b1);
		// one byte over the longest interval truncates to zero
		send_sample(EL_MAX, 64'd1, 1'b1);
		// zero elapsed with a baseline held
		send_sample('0, 64'd123, 1'b1);
		send_sample(EL_MAX, CNT_MAX, 1'b1);
		// invalid reading with every field bit set drops the baseline
		send_sample(EL_MAX, CNT_MAX, 1'b0);
		// zero elapsed without a baseline
		send_sample('0, 64'h8000_0000_0000_0000, 1'b1);
		// just below and just above the saturation edge
		send_sample(40'd1, 64'h8000_0000_0000_0000 + 64'd4503599627, 1'b1);
		send_sample(40'd1, 64'h8000_0000_0000_0000 + 64'd9007199255, 1'b1);
		// invalid, then baseline again, then an ordinary rate
		send_sample(40'd7, 64'd5, 1'b0);
		send_sample(40'd7, 64'd5, 1'b1);
		send_sample(40'h55_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
		send_sample(40'hAA_AAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
		run_count = 64'hAAAA_AAAA_AAAA_AAAA;

		// random part: mostly a rising counter, with breaks and noise mixed in
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 3) begin
				src_idle_pct = 73;
				snk_idle_pct = 22;
			end
			if (i == 2 * N_RANDOM / 3) begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end
			pick = $urandom_range(99);
			el   = rand_elapsed();
			cnt  = rand_count();
			cv   = 1'b1;
			if (pick < 4) begin
				cv = 1'b0;
			end else if (pick < 7) begin
				el = '0;
			end else if (pick < 10) begin
				cnt = run_count - (rand_count() >> $urandom_range(63)) - 64'd1;
			end else if (pick < 13) begin
				cv = 1'($urandom_range(1));
			end else begin
				el = rand_elapsed() >> $urandom_range(39);
				if (el == '0)
					el = 40'd1;
				cnt = run_count + (rand_count() >> $urandom_range(64));
			end
			if (cv)
				run_count = cnt;
			send_sample(el, cnt, cv);
		end
		sample.valid <= 1'b0;

		// drain outstanding results
		while (sb.pending_rates.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> counter_delta_bandwidth_meter.f
rtl/core/cdbm_pkg.sv
rtl/core/cdbm_in_if.sv
rtl/core/cdbm_out_if.sv
rtl/core/cdbm_ctrl.sv
rtl/core/cdbm_dp.sv
rtl/core/counter_delta_bandwidth_meter.sv
sim/tb_counter_delta_bandwidth_meter.sv
